>>> src/zmp_pkg.sv
// Shared types and constants of the zoom motion profiler.
package zmp_pkg;

  localparam int FRAC_BITS = 8;
  localparam int TOL_C     = ((1 << FRAC_BITS) + 5) / 10;
  localparam int ONE_LEN   = 1 << FRAC_BITS;

  localparam logic [22:0] ZOOM_MIN_RST = 23'd76800;
  localparam logic [22:0] ZOOM_MAX_RST = 23'd256000;
  localparam logic [22:0] MAX_SPD_RST  = 23'd256000;
  localparam logic [23:0] ACCEL_RST    = 24'd1280000;
  localparam logic [15:0] SCROLL_RST   = 16'd6554;
  localparam logic [23:0] POS_RST      = 24'((int'(ZOOM_MIN_RST) + int'(ZOOM_MAX_RST)) / 2);

  // Number of quotient bits of the braking-rate divider.
  localparam int DIV_BITS = 47;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_SET      = 3'd1,
    MODE_OFFSET   = 3'd2,
    MODE_FRAC     = 3'd3,
    MODE_FRAC_OFF = 3'd4,
    MODE_SCROLL   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    CFG_ZOOM_MIN  = 3'd0,
    CFG_ZOOM_MAX  = 3'd1,
    CFG_MAX_SPEED = 3'd2,
    CFG_ACCEL     = 3'd3,
    CFG_SCROLL    = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_CMD,
    OP_SET,
    OP_STOP,
    OP_MUL_SQ,
    OP_MUL_BRK,
    OP_DECIDE,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_BOOST,
    OP_SPEED,
    OP_MUL_POS,
    OP_POS,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MULC,
    ST_SET,
    ST_TICK_SQ,
    ST_TICK_BRK,
    ST_DECIDE,
    ST_DIV,
    ST_DIV_END,
    ST_BOOST,
    ST_SPEED,
    ST_MULP,
    ST_POS,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       active;
    logic       run;
    logic       need_div;
    logic       div_last;
  } status_t;

endpackage

>>> src/zmp_ctrl.sv
// Sequencing state machine of the zoom motion profiler.
module zmp_ctrl import zmp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.mode)
          MODE_TICK:     state_d = status_i.active ? ST_TICK_SQ : ST_FINISH;
          MODE_SET:      state_d = ST_SET;
          MODE_OFFSET:   state_d = ST_SET;
          MODE_FRAC:     state_d = ST_MULC;
          MODE_FRAC_OFF: state_d = ST_MULC;
          MODE_SCROLL:   state_d = ST_MULC;
          default:       state_d = ST_FINISH;
        endcase
      end
      ST_MULC: begin
        cmd_o.op = OP_MUL_CMD;
        state_d  = ST_SET;
      end
      ST_SET: begin
        cmd_o.op = OP_SET;
        state_d  = ST_FINISH;
      end
      ST_TICK_SQ: begin
        if (status_i.run) begin
          cmd_o.op = OP_MUL_SQ;
          state_d  = ST_TICK_BRK;
        end else begin
          cmd_o.op = OP_STOP;
          state_d  = ST_FINISH;
        end
      end
      ST_TICK_BRK: begin
        cmd_o.op = OP_MUL_BRK;
        state_d  = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        state_d  = status_i.need_div ? ST_DIV : ST_BOOST;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd_o.op = OP_DIV_END;
        state_d  = ST_BOOST;
      end
      ST_BOOST: begin
        cmd_o.op = OP_MUL_BOOST;
        state_d  = ST_SPEED;
      end
      ST_SPEED: begin
        cmd_o.op = OP_SPEED;
        state_d  = ST_MULP;
      end
      ST_MULP: begin
        cmd_o.op = OP_MUL_POS;
        state_d  = ST_POS;
      end
      ST_POS: begin
        cmd_o.op = OP_POS;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/zmp_datapath.sv
// Registers, shared multiplier and braking-rate divider of the zoom motion profiler.
module zmp_datapath import zmp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic [2:0]         in_mode_i,
  input  logic signed [23:0] in_value_i,
  input  logic [15:0]        in_dt_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic signed [23:0] out_pos_o,
  output logic               out_moving_o
);

  logic [22:0] zmin_q, zmax_q, cap_q;
  logic [23:0] accel_q;
  logic [15:0] sf_q;

  logic [2:0]         mode_q;
  logic signed [23:0] value_q;
  logic [15:0]        dt_q;

  logic signed [23:0] pos_q, pos_d, tgt_q, tgt_d, spd_q, spd_d;
  logic               braking_q, braking_d, active_q, active_d, stop_q, stop_d;
  logic signed [31:0] brake_q, brake_d;
  logic signed [32:0] boost_q, boost_d;
  logic [46:0]        sq_q, sq_d;
  logic signed [58:0] prod_q, prod_d;
  logic [46:0]        num_q, num_d, quo_q, quo_d;
  logic [25:0]        rem_q, rem_d;
  logic [5:0]         cnt_q, cnt_d;
  logic signed [23:0] opos_q;
  logic               omov_q;

  logic signed [24:0] delta;
  logic [24:0]        adelta;
  logic [23:0]        aspeed;
  logic signed [23:0] range;
  logic [23:0]        a_eff;
  logic               same, run, need_div;
  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [58:0] mul_p;
  logic signed [42:0] sh16;
  logic signed [33:0] sh15, tcand, tcl;
  logic signed [24:0] tdiff;
  logic [26:0]        rem_sh;
  logic [26:0]        dvs;
  logic signed [43:0] ssum, scap;
  logic signed [43:0] psum;
  logic signed [31:0] rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zmin_q  <= ZOOM_MIN_RST;
      zmax_q  <= ZOOM_MAX_RST;
      cap_q   <= MAX_SPD_RST;
      accel_q <= ACCEL_RST;
      sf_q    <= SCROLL_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ZOOM_MIN:  zmin_q  <= cfg_wdata_i[22:0];
        CFG_ZOOM_MAX:  zmax_q  <= cfg_wdata_i[22:0];
        CFG_MAX_SPEED: cap_q   <= cfg_wdata_i[22:0];
        CFG_ACCEL:     accel_q <= cfg_wdata_i;
        CFG_SCROLL:    sf_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_RST;
      tgt_q     <= POS_RST;
      spd_q     <= '0;
      braking_q <= 1'b0;
      brake_q   <= '0;
      active_q  <= 1'b0;
      stop_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      tgt_q     <= tgt_d;
      spd_q     <= spd_d;
      braking_q <= braking_d;
      brake_q   <= brake_d;
      active_q  <= active_d;
      stop_q    <= stop_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      mode_q  <= in_mode_i;
      value_q <= in_value_i;
      dt_q    <= in_dt_i;
    end
    if (cmd_i.op == OP_OUT) begin
      opos_q <= pos_q;
      omov_q <= active_q;
    end
    boost_q <= boost_d;
    sq_q    <= sq_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
  end

  assign delta  = 25'(tgt_q) - 25'(pos_q);
  assign adelta = delta[24] ? 25'(-delta) : 25'(delta);
  assign aspeed = spd_q[23] ? 24'(-spd_q) : 24'(spd_q);
  assign range  = $signed({1'b0, zmax_q}) - $signed({1'b0, zmin_q});
  assign a_eff  = (accel_q == '0) ? 24'd1 : accel_q;
  assign same   = (!spd_q[23] && spd_q != '0 && !delta[24] && delta != '0) ||
                  (spd_q[23] && delta[24]);
  assign run    = (adelta > 25'(TOL_C)) || (aspeed > 24'(ONE_LEN));
  assign need_div = !braking_q && ({3'b0, sq_q} >= prod_q[49:0]) && same;
  assign dvs    = {adelta, 1'b0, 1'b0} >> 1;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_CMD: begin
        mul_a = (mode_q == MODE_SCROLL) ? $signed({17'b0, sf_q}) : 33'(value_q);
        mul_b = 26'(range);
      end
      OP_MUL_SQ: begin
        mul_a = 33'(spd_q);
        mul_b = 26'(spd_q);
      end
      OP_MUL_BRK: begin
        mul_a = $signed({8'b0, a_eff, 1'b0});
        mul_b = $signed({1'b0, 25'(adelta + 25'd1)});
      end
      OP_MUL_BOOST: begin
        mul_a = boost_q;
        mul_b = $signed({10'b0, dt_q});
      end
      OP_MUL_POS: begin
        mul_a = 33'(spd_q);
        mul_b = $signed({10'b0, dt_q});
      end
      default: ;
    endcase
  end

  assign mul_p = 59'(mul_a) * 59'(mul_b);
  assign sh16  = 43'(prod_q >>> 16);
  assign sh15  = 34'(prod_q >>> 15);

  // Candidate target of a target command, then the clamp.
  always_comb begin
    case (mode_q)
      MODE_SET:      tcand = 34'(value_q);
      MODE_OFFSET:   tcand = 34'(tgt_q) - 34'(value_q);
      MODE_FRAC:     tcand = $signed({11'b0, zmin_q}) + sh15;
      MODE_FRAC_OFF: tcand = 34'(tgt_q) - sh15;
      MODE_SCROLL: begin
        if (value_q > 0)      tcand = 34'(tgt_q) - 34'(sh16);
        else if (value_q < 0) tcand = 34'(tgt_q) + 34'(sh16);
        else                  tcand = 34'(tgt_q);
      end
      default:       tcand = 34'(tgt_q);
    endcase
    if (tcand < $signed({11'b0, zmin_q}))      tcl = $signed({11'b0, zmin_q});
    else if (tcand < $signed({11'b0, zmax_q})) tcl = tcand;
    else                                       tcl = $signed({11'b0, zmax_q});
    tdiff = 25'(tcl[23:0]) - 25'(pos_q);
  end

  // Braking rate from the quotient, saturated to 32 bits.
  always_comb begin
    if (!delta[24]) begin
      rate = (quo_q >= 47'h80000000) ? 32'sh80000000 : 32'(-$signed({1'b0, quo_q}));
    end else begin
      rate = (quo_q > 47'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
    end
  end

  assign rem_sh = {rem_q, num_q[46]};
  assign ssum   = 44'(spd_q) + 44'(sh16);
  assign scap   = $signed({21'b0, cap_q});
  assign psum   = 44'(pos_q) + 44'(sh16);

  always_comb begin
    pos_d     = pos_q;
    tgt_d     = tgt_q;
    spd_d     = spd_q;
    braking_d = braking_q;
    brake_d   = brake_q;
    active_d  = active_q;
    stop_d    = stop_q;
    boost_d   = boost_q;
    sq_d      = sq_q;
    prod_d    = prod_q;
    num_d     = num_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    case (cmd_i.op)
      OP_MUL_CMD, OP_MUL_BRK, OP_MUL_BOOST, OP_MUL_POS: prod_d = mul_p;
      OP_MUL_SQ: sq_d = mul_p[46:0];
      OP_SET: begin
        braking_d = 1'b0;
        tgt_d     = tcl[23:0];
        if (tdiff > 25'sd0 ? tdiff > 25'(TOL_C) : -tdiff > 25'(TOL_C)) begin
          active_d = 1'b1;
        end
      end
      OP_STOP: begin
        spd_d     = '0;
        braking_d = 1'b0;
        active_d  = 1'b0;
      end
      OP_DECIDE: begin
        stop_d = 1'b0;
        if (braking_q) begin
          if ((delta < 0 && brake_q > 0) || (delta > 0 && brake_q < 0)) begin
            boost_d = '0;
            stop_d  = 1'b1;
          end else begin
            boost_d = 33'(brake_q);
          end
        end else if (need_div) begin
          num_d = sq_q;
          rem_d = '0;
          quo_d = '0;
          cnt_d = 6'(DIV_BITS - 1);
        end else if (delta > 0) begin
          boost_d = $signed({9'b0, accel_q});
        end else if (delta < 0) begin
          boost_d = -$signed({9'b0, accel_q});
        end else begin
          boost_d = '0;
        end
      end
      OP_DIV_STEP: begin
        num_d = {num_q[45:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (rem_sh >= dvs) begin
          rem_d = 26'(rem_sh - dvs);
          quo_d = {quo_q[45:0], 1'b1};
        end else begin
          rem_d = rem_sh[25:0];
          quo_d = {quo_q[45:0], 1'b0};
        end
      end
      OP_DIV_END: begin
        braking_d = 1'b1;
        brake_d   = rate;
        boost_d   = 33'(rate);
      end
      OP_SPEED: begin
        if (ssum < -scap)     spd_d = 24'(-scap);
        else if (ssum > scap) spd_d = 24'(scap);
        else                  spd_d = ssum[23:0];
      end
      OP_POS: begin
        if (psum > 44'sd8388607)       pos_d = 24'sh7FFFFF;
        else if (psum < -44'sd8388608) pos_d = 24'sh800000;
        else                           pos_d = psum[23:0];
        if (stop_q) begin
          spd_d     = '0;
          braking_d = 1'b0;
          active_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign status_o.mode     = mode_q;
  assign status_o.active   = active_q;
  assign status_o.run      = run;
  assign status_o.need_div = need_div;
  assign status_o.div_last = (cnt_q == '0);
  assign out_pos_o         = opos_q;
  assign out_moving_o      = omov_q;

endmodule

>>> src/zoom_motion_profiler.sv
// Top level of the zoom motion profiler: stream ports, controller and datapath.
// Steps after acceptance: dispatch, set, finish for set and offset commands; a multiply
// before the set for fraction and scroll; dispatch, finish for an idle tick or unused mode;
// a stop step for a tick that stops at once; square, brake product, decide, boost, speed,
// position product, position for a moving tick; the one-bit-per-cycle divider for the braking
// rate (47 quotient bits) joins when braking starts. One word is in work at a time; the
// next is taken once the result is registered; a waiting result word holds off the input.
// Reset clears the motion state; position and target return to the limits' midpoint.
module zoom_motion_profiler import zmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value [23:0], time_step [39:24]
  input  logic [2:0]  s_axis_tuser,   // mode [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // position [23:0], moving [24], zero above
);

  cmd_t               cmd;
  status_t            status;
  logic signed [23:0] out_pos;
  logic               out_moving;

  // The controller steps through the phases of one word; the datapath
  // holds all state and does the arithmetic on its commands.
  zmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  zmp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mode_i    (s_axis_tuser),
    .in_value_i   ($signed(s_axis_tdata[23:0])),
    .in_dt_i      (s_axis_tdata[39:24]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_pos_o    (out_pos),
    .out_moving_o (out_moving)
  );

  // The output word is registered in the datapath and held until taken.
  assign m_axis_tdata = {7'b0, out_moving, out_pos};

endmodule

>>> test/zoom_motion_profiler_test.sv
// Self-checking testbench of the zoom motion profiler with a built-in motion predictor.
`timescale 1ns / 100ps

module zoom_motion_profiler_test import zmp_pkg::*; ;

  // Clock, reset and block ports.
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [23:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // value [23:0], time_step [39:24]
  logic [2:0]  s_axis_tuser;   // mode [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // position [23:0], moving [24], zero above

  zoom_motion_profiler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predicted block state, kept in 64-bit signed terms so that the intermediate
  // products never wrap before the block's own saturation points.
  longint zmin, zmax, spd_cap, acc_rate, scroll_frac;
  longint pos_q, tgt_q, vel_q;
  logic   brk_on, armed;
  int     brk_rate;

  typedef struct packed {
    logic [23:0] position;
    logic        moving;
  } zoom_word_t;

  zoom_word_t expected_words[$];

  // Idle controls: percentage of cycles in which each side holds back.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_recv;       // long receiver hold-off for the pressure test

  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned idle_cycles;
  int unsigned brake_events;

  // Floor of x / 2^s for signed x.
  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint clamp_to_limits(longint x);
    if (x < zmin) return zmin;
    if (x < zmax) return x;
    return zmax;
  endfunction

  function automatic void aim_at(longint t);
    brk_on = 1'b0;
    tgt_q  = clamp_to_limits(t);
    if (mag(tgt_q - pos_q) > TOL_C) armed = 1'b1;
  endfunction

  // One time step of the profile: accelerate, cruise or brake, then move.
  function automatic void advance_motion(longint dt);
    logic   halt;
    longint gap, boost, sq, a, stop_len, r;
    logic   toward;
    halt = 1'b0;
    gap  = tgt_q - pos_q;
    if (mag(gap) > TOL_C || mag(vel_q) > ONE_LEN) begin
      sq = vel_q * vel_q;
      if (brk_on) begin
        boost = brk_rate;
        if ((gap < 0 && brk_rate > 0) || (gap > 0 && brk_rate < 0)) begin
          boost = 0;
          halt  = 1'b1;
        end
      end else begin
        a        = (acc_rate != 0) ? acc_rate : 1;
        stop_len = sq / (2 * a);
        toward   = (vel_q > 0 && gap > 0) || (vel_q < 0 && gap < 0);
        if (stop_len > mag(gap) && toward) begin
          r = -(sq / (2 * gap));
          if (r > 64'sd2147483647) r = 64'sd2147483647;
          if (r < -64'sd2147483648) r = -64'sd2147483648;
          brk_on   = 1'b1;
          brk_rate = int'(r);
          boost    = r;
          brake_events++;
        end else begin
          boost = (gap > 0) ? acc_rate : ((gap < 0) ? -acc_rate : 0);
        end
      end
      vel_q += floor_shr(boost * dt, 16);
      if (vel_q < -spd_cap) vel_q = -spd_cap;
      else if (vel_q > spd_cap) vel_q = spd_cap;
      pos_q += floor_shr(vel_q * dt, 16);
      if (pos_q > 64'sd8388607) pos_q = 64'sd8388607;
      if (pos_q < -64'sd8388608) pos_q = -64'sd8388608;
    end else begin
      halt = 1'b1;
    end
    if (halt) begin
      vel_q  = 0;
      brk_on = 1'b0;
      armed  = 1'b0;
    end
  endfunction

  // Applies one command word to the predicted state and queues the result.
  function automatic void predict_word(logic [2:0] mode, logic [23:0] value_raw,
                                       logic [15:0] dt);
    longint     v, span, step;
    zoom_word_t w;
    v    = longint'($signed(value_raw));
    span = zmax - zmin;
    case (mode)
      MODE_TICK:     if (armed) advance_motion(longint'(dt));
      MODE_SET:      aim_at(v);
      MODE_OFFSET:   aim_at(tgt_q - v);
      MODE_FRAC:     aim_at(zmin + floor_shr(v * span, 15));
      MODE_FRAC_OFF: aim_at(tgt_q - floor_shr(v * span, 15));
      MODE_SCROLL: begin
        step = floor_shr(scroll_frac * span, 16);
        if (v > 0) aim_at(tgt_q - step);
        else if (v < 0) aim_at(tgt_q + step);
        else aim_at(tgt_q);
      end
      default: ;
    endcase
    w.position = pos_q[23:0];
    w.moving   = armed;
    expected_words.push_back(w);
  endfunction

  function automatic void reset_prediction();
    zmin        = ZOOM_MIN_RST;
    zmax        = ZOOM_MAX_RST;
    spd_cap     = MAX_SPD_RST;
    acc_rate    = ACCEL_RST;
    scroll_frac = SCROLL_RST;
    pos_q       = (zmin + zmax) / 2;
    tgt_q       = pos_q;
    vel_q       = 0;
    brk_on      = 1'b0;
    brk_rate    = 0;
    armed       = 1'b0;
  endfunction

  // Sends one word, idling first at random, and predicts its result on acceptance.
  // The valid line stays up after acceptance; the next word or the drain takes it down.
  task automatic send_word(logic [2:0] mode, logic [23:0] value_raw, logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {dt, value_raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(mode, value_raw, dt);
    words_sent++;
  endtask

  // Waits until every result has come back, plus the longest tick latency.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ZOOM_MIN:  zmin        = data[22:0];
      CFG_ZOOM_MAX:  zmax        = data[22:0];
      CFG_MAX_SPEED: spd_cap     = data[22:0];
      CFG_ACCEL:     acc_rate    = data;
      CFG_SCROLL:    scroll_frac = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [22:0] lo, logic [22:0] hi, logic [22:0] cap,
                           logic [23:0] acc, logic [15:0] scr);
    write_reg(CFG_ZOOM_MIN, lo);
    write_reg(CFG_ZOOM_MAX, hi);
    write_reg(CFG_MAX_SPEED, cap);
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_SCROLL, scr);
    cfg_we_i <= 1'b0;
  endtask

  // Random target command; modes 6 and 7 show up rarely as noise.
  task automatic send_random_command();
    logic [2:0]  m;
    logic [23:0] v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) m = 3'($urandom_range(7, 6));
    else m = 3'($urandom_range(MODE_SCROLL, MODE_SET));
    case ($urandom_range(3))
      0: v = 24'($urandom);
      1: v = 24'($urandom_range(zmax > 0 ? zmax : 1));
      2: v = 24'($signed(24'($urandom_range(65535))) - 24'sd32768);
      default: v = 24'($urandom_range(40000)) - 24'd20000;
    endcase
    send_word(m, v, 16'($urandom));
  endtask

  // Random tick; most steps are short so that motions take several ticks.
  task automatic send_random_tick();
    logic [15:0] dt;
    case ($urandom_range(7))
      0: dt = 16'($urandom);
      1: dt = 16'($urandom_range(3));
      default: dt = 16'($urandom_range(4000, 200));
    endcase
    send_word(MODE_TICK, 24'($urandom), dt);
  endtask

  // A move command followed by a run of ticks, so that most motions reach the
  // braking phase and come to rest.
  task automatic send_random_move(int unsigned ticks);
    send_random_command();
    repeat (ticks) send_random_tick();
  endtask

  // Result checker: compares each accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    zoom_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.position = m_axis_tdata[23:0];
      got.moving   = m_axis_tdata[24];
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %h", m_axis_tdata);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got.position !== want.position || got.moving !== want.moving ||
            m_axis_tdata[31:25] !== 7'd0) begin
          errors++;
          if (errors <= 10)
            $display("word %0d mismatch: position exp %h got %h, moving exp %b got %b",
                     words_checked, want.position, got.position, want.moving, got.moving);
        end
      end
    end
  end

  // Receiver: random stalls, or a full hold-off while the pressure test runs.
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: ends the run after a long stretch without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_recv)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
        $display("timeout: no word moved for 20000 cycles");
        $display("[zoom_motion_profiler] ERROR");
        $finish;
      end
    end
  end

  // Directed: field extremes, every mode, clamping, saturation.
  task automatic test_directed();
    send_word(MODE_TICK, 24'h000000, 16'hFFFF);         // tick while idle
    send_word(MODE_SET, 24'h7FFFFF, 16'h0000);          // clamps to the upper limit
    send_word(MODE_TICK, 24'hFFFFFF, 16'hFFFF);
    send_word(MODE_SET, 24'h800000, 16'hFFFF);          // clamps to the lower limit
    send_word(MODE_TICK, 24'h000000, 16'h1000);
    send_word(MODE_SET, 24'(pos_q + 10), 16'h0);        // target within tolerance
    send_word(MODE_OFFSET, 24'hFFD800, 16'h0);
    send_word(MODE_FRAC, 24'h008000, 16'h0);            // full range fraction
    send_word(MODE_FRAC, 24'hFF8000, 16'h0);            // negative fraction
    send_word(MODE_FRAC_OFF, 24'h004000, 16'h0);
    send_word(MODE_SCROLL, 24'h000001, 16'h0);
    send_word(MODE_SCROLL, 24'hFFFFFF, 16'h0);
    send_word(MODE_SCROLL, 24'h000000, 16'h0);
    send_word(3'd6, 24'h123456, 16'h5555);              // unused modes are ignored
    send_word(3'd7, 24'hABCDEF, 16'hAAAA);
    repeat (10) send_word(MODE_TICK, 24'h0, 16'h0800);
    drain();
  endtask

  // Random moves under the given idling percentages.
  task automatic test_random_moves(int unsigned moves, int unsigned src_pct,
                                   int unsigned dst_pct);
    send_idle_pct  = src_pct;
    recv_stall_pct = dst_pct;
    repeat (moves) send_random_move($urandom_range(14, 2));
    drain();
  endtask

  // Register sweep: extremes including inverted limits, zero accel and scroll.
  task automatic test_register_extremes();
    write_all(23'h7FFFFF, 23'd0, 23'd1, 24'd0, 16'hFFFF);  // inverted limits
    repeat (40) send_random_move(3);
    drain();
    write_all(23'd0, 23'h7FFFFF, 23'h7FFFFF, 24'hFFFFFF, 16'd0);
    repeat (40) send_random_move(6);
    drain();
    // Full range with huge steps drives the position to its saturation points.
    write_all(23'd0, 23'h7FFFFF, 23'h7FFFFF, 24'hFFFFFF, 16'hFFFF);
    send_word(MODE_SET, 24'h7FFFFF, 16'h0);
    repeat (4) send_word(MODE_TICK, 24'h0, 16'hFFFF);
    send_word(MODE_SET, 24'h000000, 16'h0);
    repeat (4) send_word(MODE_TICK, 24'h0, 16'hFFFF);
    drain();
  endtask

  // Pressure: the receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    send_idle_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      repeat (12) send_random_move(4);
    join
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_recv     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors = 0; words_sent = 0; words_checked = 0; idle_cycles = 0; brake_events = 0;
    reset_prediction();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_random_moves(28, 0, 0);
    test_random_moves(28, 66, 0);
    write_all(23'd12800, 23'd64000, 23'd30000, 24'd200000, 16'd20000);
    test_random_moves(28, 0, 66);
    test_random_moves(28, 29, 29);
    test_register_extremes();
    write_all(ZOOM_MIN_RST, ZOOM_MAX_RST, MAX_SPD_RST, ACCEL_RST, SCROLL_RST);
    test_backpressure();
    test_random_moves(30, 0, 0);

    $display("covered %0d command words with %0d results checked, %0d braking starts,",
             words_sent, words_checked, brake_events);
    $display("across idle and stall phases, a long output hold-off and register extremes");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("[zoom_motion_profiler] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_words.size());
      $display("[zoom_motion_profiler] ERROR");
    end
    $finish;
  end

endmodule
